>>> rtl/core/atp_pkg.sv
// Shared constants and types for the Q12 arctangent pipeline.
// No dependencies.
package atp_pkg;

	localparam int DefInputWidth = 20;
	localparam int FracBits      = 12;
	localparam int AngleWidth    = 15;
	localparam int RatioWidth    = 13;

	localparam logic signed [AngleWidth-1:0] AngPi     = 15'sd12868;
	localparam logic signed [AngleWidth-1:0] AngHalfPi = 15'sd6434;

	localparam logic signed [15:0] PolyC4 = 16'sd580;
	localparam logic signed [15:0] PolyC3 = -16'sd1406;
	localparam logic signed [15:0] PolyC2 = -16'sd66;
	localparam logic signed [15:0] PolyC1 = 16'sd4112;
	localparam logic signed [31:0] PolyC0 = -32'sd4096;

	// Octant / quadrant flags and special-case result travel together.
	typedef struct packed {
		logic                         special;
		logic signed [AngleWidth-1:0] special_angle;
		logic                         swap;
		logic                         x_neg;
		logic                         y_neg;
	} fold_t;

endpackage

>>> rtl/core/atp_div.sv
// Pipelined restoring divider: quotient = (mn << 12) / mx, one bit per stage.
// Depends on atp_pkg. Side data (fold_t) travels with each request.
module atp_div #(
	parameter int W = atp_pkg::DefInputWidth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [W-1:0]                         mn,
	input  logic [W-1:0]                         mx,
	input  atp_pkg::fold_t                       in_fold,
	output logic                                 out_valid,
	output logic [atp_pkg::RatioWidth-1:0]       quot,
	output atp_pkg::fold_t                       out_fold
);
	import atp_pkg::*;

	// Quotient is at most 4096, so 13 bits of quotient are produced.
	localparam int NSt = RatioWidth;

	logic [W:0]            rem_q  [NSt+1];
	logic [W-1:0]          mx_q   [NSt+1];
	logic [W-1:0]          num_q  [NSt+1];
	logic [NSt-1:0]        quo_q  [NSt+1];
	fold_t                 fold_q [NSt+1];
	logic [NSt:0]          vld_q;

	// Stage 0 capture. Dividend is mn*2^12; its top bits (mn >> 1) seed the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		rem_q[0]  <= {2'b00, mn[W-1:1]};
		num_q[0]  <= mn;
		mx_q[0]   <= mx;
		quo_q[0]  <= '0;
		fold_q[0] <= in_fold;
	end

	// One quotient bit per stage; dividend bits: mn[0] then twelve zeros.
	for (genvar g = 0; g < NSt; g++) begin : g_st
		logic [W+1:0] trial;
		logic         nb;
		assign nb    = (g == 0) ? num_q[g][0] : 1'b0;
		assign trial = {rem_q[g], nb} - {2'b00, mx_q[g]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else begin
				vld_q[g+1] <= vld_q[g];
			end
		end
		always_ff @(posedge clk) begin
			if (!trial[W+1]) begin
				rem_q[g+1] <= trial[W:0];
			end else begin
				rem_q[g+1] <= {rem_q[g][W-1:0], nb};
			end
			quo_q[g+1]  <= {quo_q[g][NSt-2:0], ~trial[W+1]};
			num_q[g+1]  <= num_q[g];
			mx_q[g+1]   <= mx_q[g];
			fold_q[g+1] <= fold_q[g];
		end
	end

	assign out_valid = vld_q[NSt];
	assign quot      = quo_q[NSt];
	assign out_fold  = fold_q[NSt];

endmodule

>>> rtl/core/atp_poly.sv
// Polynomial evaluation and octant/quadrant fold, four register stages.
// Depends on atp_pkg.
module atp_poly (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [atp_pkg::RatioWidth-1:0]        a,
	input  atp_pkg::fold_t                        in_fold,
	output logic                                  out_valid,
	output logic signed [atp_pkg::AngleWidth-1:0] angle
);
	import atp_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	fold_t       f_s1, f_s2, f_s3, f_s4;
	logic [12:0] a_s1, a_s2, a_s3;
	logic [12:0] a2_s1, a2_s2, a2_s3;
	logic [12:0] a3_s2, a3_s3;
	logic [12:0] a4_s3;
	logic signed [AngleWidth-1:0] ang_s4;

	logic [25:0] p2, p3, p4;
	logic signed [31:0] sum;
	logic signed [19:0] r;
	logic signed [16:0] rf1, rf2, rf3;

	assign p2 = a * a;
	assign p3 = a2_s1 * a_s1;
	assign p4 = a3_s2 * a_s2;

	// Weighted sum and floor shift (>>> on signed is floor)
	always_comb begin
		sum = $signed({1'b0, a4_s3}) * PolyC4 + $signed({1'b0, a3_s3}) * PolyC3
			+ $signed({1'b0, a2_s3}) * PolyC2 + $signed({1'b0, a_s3}) * PolyC1 + PolyC0;
		r   = 20'(sum >>> FracBits);
		rf1 = f_s3.swap  ? 17'(AngHalfPi) - 17'(r) : 17'(r);
		rf2 = f_s3.x_neg ? 17'(AngPi) - rf1 : rf1;
		rf3 = f_s3.y_neg ? -rf2 : rf2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Powers of a, one product per stage
	always_ff @(posedge clk) begin
		a_s1   <= a;
		a2_s1  <= p2[24:12];
		f_s1   <= in_fold;
		a_s2   <= a_s1;
		a2_s2  <= a2_s1;
		a3_s2  <= p3[24:12];
		f_s2   <= f_s1;
		a_s3   <= a_s2;
		a2_s3  <= a2_s2;
		a3_s3  <= a3_s2;
		a4_s3  <= p4[24:12];
		f_s3   <= f_s2;
		f_s4   <= f_s3;
		ang_s4 <= f_s3.special ? f_s3.special_angle : AngleWidth'(rf3);
	end

	assign out_valid = v_s4;
	assign angle     = ang_s4;

	// Special cases never exceed half pi in magnitude (or pi)
	a_spec: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && f_s4.special) |-> (angle == 0 || angle == AngHalfPi
			|| angle == -AngHalfPi || angle == AngPi))
		else $error("bad special-case angle");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (angle <= AngPi + 1 && angle >= -(AngPi + 1)))
		else $error("angle out of range");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##4 out_valid)
		else $error("valid lost in polynomial pipe");

endmodule

>>> rtl/core/atan2_poly_q12.sv
// atan2_poly_q12: a fully pipelined four-quadrant arctangent. A request is
// taken on every cycle with start high (busy is always low); its angle comes out
// on done after 1 input stage, 14 divider stages and 4 poly stages.
// The receiver cannot stall and results are never held. Angle is Q12 radians.
// Depends on atp_pkg, atp_div, atp_poly.
module atan2_poly_q12 #(
	parameter int INPUT_WIDTH = atp_pkg::DefInputWidth
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [INPUT_WIDTH-1:0]         y_value,
	input  logic signed [INPUT_WIDTH-1:0]         x_value,
	output logic                                  done,
	output logic signed [atp_pkg::AngleWidth-1:0] angle
);
	import atp_pkg::*;

	localparam int W = INPUT_WIDTH;

	logic         v_s1;
	logic [W-1:0] mn_s1, mx_s1;
	fold_t        f_s1, f_in;
	logic [W-1:0] ay, ax;
	logic         dv;
	logic [RatioWidth-1:0] q;
	fold_t        df;

	assign busy = 1'b0;

	// Magnitudes, octant flags and special cases
	always_comb begin
		ay = y_value[W-1] ? W'(-y_value) : W'(y_value);
		ax = x_value[W-1] ? W'(-x_value) : W'(x_value);
		f_in.swap  = ay > ax;
		f_in.x_neg = x_value[W-1];
		f_in.y_neg = y_value[W-1];
		f_in.special = (x_value == '0) || (y_value == '0);
		if (x_value == '0) begin
			f_in.special_angle = (y_value == '0) ? '0 :
				(y_value[W-1] ? -AngHalfPi : AngHalfPi);
		end else begin
			f_in.special_angle = x_value[W-1] ? AngPi : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end
	always_ff @(posedge clk) begin
		mn_s1 <= f_in.swap ? ax : ay;
		mx_s1 <= f_in.swap ? ay : ax;
		f_s1  <= f_in;
	end

	atp_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1),
		.mn(mn_s1), .mx((mx_s1 == '0) ? W'(1) : mx_s1), .in_fold(f_s1),
		.out_valid(dv), .quot(q), .out_fold(df)
	);

	atp_poly u_poly (
		.clk(clk), .arst_n(arst_n), .in_valid(dv), .a(q), .in_fold(df),
		.out_valid(done), .angle(angle)
	);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##14 dv)
		else $error("divider latency broken");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dv, 4))
		else $error("done without request");

endmodule

>>> bench/atan2_checker.sv
// Checker for atan2_poly_q12: watches accepted requests and done strobes,
// predicts each Q12 angle and compares it in order. Depends on atp_pkg.
module atan2_checker #(
	parameter int INPUT_WIDTH = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic signed [INPUT_WIDTH-1:0]         y_value,
	input  logic signed [INPUT_WIDTH-1:0]         x_value,
	input  logic                                  done,
	input  logic signed [atp_pkg::AngleWidth-1:0] angle,
	output int                                    fail_count,
	output int                                    pending,
	output int                                    angles_checked
);
	import atp_pkg::*;

	logic signed [AngleWidth-1:0] angle_queue[$];

	// Q12 arctangent of one request, quadrant folding included
	function automatic logic signed [AngleWidth-1:0] q12_atan2(
		input logic signed [INPUT_WIDTH-1:0] yv,
		input logic signed [INPUT_WIDTH-1:0] xv);
		longint yy, xx, ay, ax, lo, hi, q, q2, q3, q4, r;
		yy = yv;
		xx = xv;
		if (xx == 0)
			return (yy == 0) ? '0 : ((yy > 0) ? AngHalfPi : -AngHalfPi);
		if (yy == 0)
			return (xx > 0) ? '0 : AngPi;
		ay = (yy < 0) ? -yy : yy;
		ax = (xx < 0) ? -xx : xx;
		lo = (ay < ax) ? ay : ax;
		hi = (ay < ax) ? ax : ay;
		q  = (lo <<< FracBits) / hi;
		q2 = (q * q) >>> FracBits;
		q3 = (q2 * q) >>> FracBits;
		q4 = (q3 * q) >>> FracBits;
		r  = (q4 * longint'(PolyC4) + q3 * longint'(PolyC3) + q2 * longint'(PolyC2)
			+ q * longint'(PolyC1) + longint'(PolyC0)) >>> FracBits;
		if (ay > ax)
			r = longint'(AngHalfPi) - r;
		if (xx < 0)
			r = longint'(AngPi) - r;
		if (yy < 0)
			r = -r;
		return r[AngleWidth-1:0];
	endfunction

	// record predictions and compare results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count     <= 0;
			angles_checked <= 0;
			pending        <= 0;
			angle_queue.delete();
		end else begin
			if (start && !busy)
				angle_queue.push_back(q12_atan2(y_value, x_value));
			if (done) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: angle %0d with no request waiting", $realtime, angle);
					fail_count <= fail_count + 1;
				end else begin
					if (angle !== angle_queue[0]) begin
						$display("%0t: angle expected %0d actual %0d", $realtime,
							angle_queue[0], angle);
						fail_count <= fail_count + 1;
					end
					void'(angle_queue.pop_front());
					angles_checked <= angles_checked + 1;
				end
			end
			pending <= angle_queue.size();
		end
	end

endmodule

>>> bench/testbench.sv
// Top of the atan2_poly_q12 bench: clock, reset, request stimulus and verdict.
// Depends on atp_pkg, atan2_poly_q12 and atan2_checker.
module testbench;
	localparam int W = 20;
	localparam int MaxMag = (1 << (W-1)) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [W-1:0] y_value = '0, x_value = '0;
	logic signed [atp_pkg::AngleWidth-1:0] angle;
	int fail_count, pending, angles_checked;
	int directed_cnt, random_cnt;

	always #4 clk = ~clk;

	atan2_poly_q12 #(.INPUT_WIDTH(W)) i_dut (.*);
	atan2_checker #(.INPUT_WIDTH(W)) i_chk (.*);

	// issue one request and hold it until accepted
	task automatic send_request(input logic signed [W-1:0] yv, input logic signed [W-1:0] xv);
		start   <= 1'b1;
		y_value <= yv;
		x_value <= xv;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// random operand: mostly full range, sometimes tiny, sometimes extreme
	function automatic logic signed [W-1:0] rand_operand();
		case ($urandom_range(9))
			0: return W'($signed($urandom_range(8)) - 4);
			1: return $urandom_range(1) ? W'(MaxMag) : -W'(MaxMag);
			2: return W'($urandom_range(2) - 1) * W'($urandom_range(300));
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [W-1:0] yv, xv;
		int burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zeros, axes, extremes, equal magnitudes, tiny ratios
		send_request(0, 0);
		send_request(5, 0);
		send_request(-5, 0);
		send_request(0, 7);
		send_request(0, -7);
		send_request(MaxMag, MaxMag);
		send_request(-MaxMag, MaxMag);
		send_request(MaxMag, -MaxMag);
		send_request(-MaxMag, -MaxMag);
		send_request(1, MaxMag);
		send_request(1, -MaxMag);
		send_request(-1, -MaxMag);
		send_request(MaxMag, 1);
		send_request(MaxMag, -1);
		send_request(-MaxMag, 1);
		send_request(-W'(1 << (W-1)), 3);
		send_request(3, -W'(1 << (W-1)));
		send_request(-W'(1 << (W-1)), -W'(1 << (W-1)));
		send_request(W'('h55555), W'('haaaaa));
		send_request(W'('haaaaa), W'('h55555));
		directed_cnt = 20;
		// let the pipe drain completely once
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		// random bursts with random gaps
		random_cnt = 0;
		while (random_cnt < 500) begin
			burst = $urandom_range(40, 1);
			for (int k = 0; k < burst; k++) begin
				yv = rand_operand();
				xv = rand_operand();
				send_request(yv, xv);
				random_cnt++;
			end
			if ($urandom_range(3) != 0)
				pause_sender($urandom_range(25, 1));
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		$display("Sent %0d directed and %0d random requests; %0d angles checked.",
			directed_cnt, random_cnt, angles_checked);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> atan2_poly_q12.f
rtl/core/atp_pkg.sv
rtl/core/atp_div.sv
rtl/core/atp_poly.sv
rtl/core/atan2_poly_q12.sv
bench/atan2_checker.sv
bench/testbench.sv
